[hdl/prl_pkg.sv]
// shared constants, opcodes, status codes and types for the positional record list
// no dependencies; compile first
`default_nettype none

package prl_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam int OPC_W  = 4;
  localparam int POS_W  = 5;
  localparam int STAT_W = 3;
  localparam int EIDX_W = 4;
  localparam int ECNT_W = 5;

  localparam logic [OPC_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OPC_W-1:0] OP_INS_BACK  = 4'd1;
  localparam logic [OPC_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OPC_W-1:0] OP_DEL_FRONT = 4'd3;
  localparam logic [OPC_W-1:0] OP_DEL_BACK  = 4'd4;
  localparam logic [OPC_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OPC_W-1:0] OP_READ_ALL  = 4'd6;
  localparam logic [OPC_W-1:0] OP_UPDATE    = 4'd7;
  localparam logic [OPC_W-1:0] OP_SEARCH    = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_BADOP    = 3'd5;

  typedef struct packed {
    logic signed [31:0] id;
    logic [7:0]         gender;
    logic signed [31:0] salary;
    logic signed [31:0] commission;
  } record_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SH_RD,
    S_SH_WR,
    S_STORE,
    S_DEL_DONE,
    S_RA_RD,
    S_RA_OUT,
    S_SR_RD,
    S_SR_CMP,
    S_UP_RD,
    S_UP_WR
  } state_t;

  typedef struct packed {
    logic              in_ready;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic              wsel_in;
    logic              inc;
    logic              dec;
    logic              load_out;
    logic [STAT_W-1:0] out_status;
    logic [EIDX_W-1:0] out_idx;
    logic              out_rec;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic              in_fire;
    logic [OPC_W-1:0]  opcode;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic              out_free;
    logic              key_match;
  } dp_sts_t;

endpackage

`default_nettype wire

[hdl/prl_if.sv]
// valid/ready channel interfaces for operation beats and result beats
// depends on prl_pkg
`default_nettype none

interface prl_in_if;
  logic                        valid;
  logic                        ready;
  logic [prl_pkg::OPC_W-1:0]   opcode;
  logic [prl_pkg::POS_W-1:0]   position;
  logic signed [31:0]          record_id;
  logic [7:0]                  record_gender;
  logic signed [31:0]          record_salary;
  logic signed [31:0]          record_commission;

  modport source (
    output valid, opcode, position, record_id, record_gender, record_salary,
           record_commission,
    input  ready
  );
  modport sink (
    input  valid, opcode, position, record_id, record_gender, record_salary,
           record_commission,
    output ready
  );
endinterface

interface prl_out_if;
  logic                        valid;
  logic                        ready;
  logic [prl_pkg::STAT_W-1:0]  status;
  logic [prl_pkg::EIDX_W-1:0]  entry_index;
  logic signed [31:0]          out_id;
  logic [7:0]                  out_gender;
  logic signed [31:0]          out_salary;
  logic signed [31:0]          out_commission;
  logic [prl_pkg::ECNT_W-1:0]  entry_count;
  logic                        last;

  modport source (
    output valid, status, entry_index, out_id, out_gender, out_salary, out_commission,
           entry_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, out_id, out_gender, out_salary, out_commission,
           entry_count, last,
    output ready
  );
endinterface

`default_nettype wire

[hdl/positional_record_list_unit.sv]
// Positional record list: an ordered list of up to CAPACITY records
// (id, gender byte, salary, commission) driven by one opcode per beat.
// in_ch carries one operation per beat: insert/delete at front, back or
// a position, read all, update at a position (returns the old record)
// or search by id. out_ch carries result beats with status, index, record,
// entry count after the operation and a last flag; read all gives one beat
// per entry, every other operation exactly one.
// After acceptance the controller enters a decode state, then per operation:
//   errors and unknown opcodes: the error beat loads from the decode state
//   insert/delete: a read and a write state per shifted entry, then store/done
//   update: read, write; search: read+compare per entry; read all: read+out per beat
// The record memory has one read and one write port, so each shifted or
// compared entry takes a read state and a use state. One operation is in
// flight at a time; in_ch.ready is high only when the controller is idle,
// which it is in the cycle after the last result beat enters the result register.
// Reset (rst_n low, synchronous) empties the list; memory contents are not
// cleared. While out_ch.ready is low the result beat holds and the block
// waits before loading the next one.
// depends on prl_pkg, prl_if, prl_ctrl and prl_datapath
`default_nettype none

module positional_record_list_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  prl_in_if.sink    in_ch,
  prl_out_if.source out_ch
);

  prl_pkg::dp_cmd_t cmd;
  prl_pkg::dp_sts_t sts;

  prl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  prl_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

[hdl/prl_datapath.sv]
// datapath: operation latch, record memory, entry count and result register
// depends on prl_pkg and prl_if
`default_nettype none

module prl_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  prl_in_if.sink                in_ch,
  prl_out_if.source             out_ch,
  input  wire prl_pkg::dp_cmd_t cmd,
  output prl_pkg::dp_sts_t      sts
);

  logic                         in_fire;
  logic [prl_pkg::OPC_W-1:0]    opcode_r;
  logic [prl_pkg::POS_W-1:0]    pos_r;
  prl_pkg::record_t             in_rec_r;
  prl_pkg::record_t             rd_r;
  prl_pkg::record_t             wdata;
  prl_pkg::record_t             mem [prl_pkg::CAPACITY];
  logic [prl_pkg::CNT_W-1:0]    count_r;
  logic [prl_pkg::CNT_W-1:0]    count_nxt;
  logic                         out_valid_r;
  logic [prl_pkg::STAT_W-1:0]   status_r;
  logic [prl_pkg::EIDX_W-1:0]   idx_r;
  prl_pkg::record_t             rec_r;
  logic [prl_pkg::CNT_W-1:0]    cnt_out_r;
  logic                         last_r;

  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      opcode_r            <= in_ch.opcode;
      pos_r               <= in_ch.position;
      in_rec_r.id         <= in_ch.record_id;
      in_rec_r.gender     <= in_ch.record_gender;
      in_rec_r.salary     <= in_ch.record_salary;
      in_rec_r.commission <= in_ch.record_commission;
    end
  end

  // record memory, one write and one registered read per cycle
  assign wdata = cmd.wsel_in ? in_rec_r : rd_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= wdata;
    end
    rd_r <= mem[cmd.raddr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r  <= cmd.out_status;
      idx_r     <= cmd.out_idx;
      rec_r     <= cmd.out_rec ? rd_r : '0;
      cnt_out_r <= count_nxt;
      last_r    <= cmd.out_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.entry_index    = idx_r;
  assign out_ch.out_id         = rec_r.id;
  assign out_ch.out_gender     = rec_r.gender;
  assign out_ch.out_salary     = rec_r.salary;
  assign out_ch.out_commission = rec_r.commission;
  assign out_ch.entry_count    = prl_pkg::ECNT_W'(cnt_out_r);
  assign out_ch.last           = last_r;

  assign sts.in_fire   = in_fire;
  assign sts.opcode    = opcode_r;
  assign sts.pos       = pos_r;
  assign sts.count     = count_r;
  assign sts.out_free  = ~out_valid_r | out_ch.ready;
  assign sts.key_match = (rd_r.id == in_rec_r.id);

endmodule

`default_nettype wire

[hdl/prl_ctrl.sv]
// controller: decodes the latched operation and sequences shifts, reads, updates and searches
// depends on prl_pkg
`default_nettype none

module prl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire prl_pkg::dp_sts_t sts,
  output prl_pkg::dp_cmd_t      cmd
);

  prl_pkg::state_t           state_r, state_nxt;
  logic [prl_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic [prl_pkg::CNT_W-1:0] at_r, at_nxt;
  logic                      ins_r, ins_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prl_pkg::S_IDLE;
      ptr_r   <= '0;
      at_r    <= '0;
      ins_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      at_r    <= at_nxt;
      ins_r   <= ins_nxt;
    end
  end

  always_comb begin
    int unsigned                cnt;
    int unsigned                pos;
    int unsigned                p;
    int unsigned                at;
    logic                       err;
    logic [prl_pkg::STAT_W-1:0] err_st;
    logic                       lst;

    cnt    = 32'(sts.count);
    pos    = 32'(sts.pos);
    p      = 32'(ptr_r);
    at     = 0;
    err    = 1'b0;
    err_st = prl_pkg::ST_OK;
    lst    = ((p + 1) == cnt) || ((p + 1) == prl_pkg::MAX_RESULTS);

    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    at_nxt    = at_r;
    ins_nxt   = ins_r;

    cmd            = '0;
    cmd.raddr      = ptr_r[prl_pkg::IDX_W-1:0];
    cmd.waddr      = ptr_r[prl_pkg::IDX_W-1:0];
    cmd.out_idx    = prl_pkg::EIDX_W'(ptr_r);
    cmd.out_status = prl_pkg::ST_OK;

    unique case (state_r)
      prl_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) begin
          state_nxt = prl_pkg::S_DECODE;
        end
      end

      prl_pkg::S_DECODE: begin
        unique case (sts.opcode) inside
          prl_pkg::OP_INS_FRONT, prl_pkg::OP_INS_BACK, prl_pkg::OP_INS_AT: begin
            at = (sts.opcode == prl_pkg::OP_INS_FRONT) ? 0 :
                 (sts.opcode == prl_pkg::OP_INS_BACK) ? cnt : pos;
            if (cnt >= prl_pkg::CAPACITY) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_FULL;
            end else if (at > cnt) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_BADPOS;
            end else begin
              ptr_nxt   = prl_pkg::CNT_W'(cnt);
              at_nxt    = prl_pkg::CNT_W'(at);
              ins_nxt   = 1'b1;
              state_nxt = (cnt > at) ? prl_pkg::S_SH_RD : prl_pkg::S_STORE;
            end
          end
          prl_pkg::OP_DEL_FRONT, prl_pkg::OP_DEL_BACK, prl_pkg::OP_DEL_AT: begin
            at = (sts.opcode == prl_pkg::OP_DEL_FRONT) ? 0 :
                 (sts.opcode == prl_pkg::OP_DEL_BACK) ? (cnt - 1) : pos;
            if (cnt == 0) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_EMPTY;
            end else if (at >= cnt) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_BADPOS;
            end else begin
              ptr_nxt   = prl_pkg::CNT_W'(at);
              at_nxt    = prl_pkg::CNT_W'(at);
              ins_nxt   = 1'b0;
              state_nxt = ((at + 1) < cnt) ? prl_pkg::S_SH_RD : prl_pkg::S_DEL_DONE;
            end
          end
          prl_pkg::OP_READ_ALL: begin
            if (cnt == 0) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_EMPTY;
            end else begin
              ptr_nxt   = '0;
              state_nxt = prl_pkg::S_RA_RD;
            end
          end
          prl_pkg::OP_UPDATE: begin
            if (cnt == 0) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_EMPTY;
            end else if (pos >= cnt) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_BADPOS;
            end else begin
              ptr_nxt   = prl_pkg::CNT_W'(pos);
              state_nxt = prl_pkg::S_UP_RD;
            end
          end
          prl_pkg::OP_SEARCH: begin
            if (cnt == 0) begin
              err    = 1'b1;
              err_st = prl_pkg::ST_EMPTY;
            end else begin
              ptr_nxt   = '0;
              state_nxt = prl_pkg::S_SR_RD;
            end
          end
          default: begin
            err    = 1'b1;
            err_st = prl_pkg::ST_BADOP;
          end
        endcase
        if (err) begin
          state_nxt = prl_pkg::S_DECODE;
          if (sts.out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = err_st;
            cmd.out_idx    = '0;
            cmd.out_last   = 1'b1;
            state_nxt      = prl_pkg::S_IDLE;
          end
        end
      end

      prl_pkg::S_SH_RD: begin
        cmd.raddr = ins_r ? prl_pkg::IDX_W'(p - 1) : prl_pkg::IDX_W'(p + 1);
        state_nxt = prl_pkg::S_SH_WR;
      end

      prl_pkg::S_SH_WR: begin
        cmd.we = 1'b1;
        if (ins_r) begin
          ptr_nxt   = prl_pkg::CNT_W'(p - 1);
          state_nxt = ((p - 1) > 32'(at_r)) ? prl_pkg::S_SH_RD : prl_pkg::S_STORE;
        end else begin
          ptr_nxt   = prl_pkg::CNT_W'(p + 1);
          state_nxt = ((p + 2) < cnt) ? prl_pkg::S_SH_RD : prl_pkg::S_DEL_DONE;
        end
      end

      prl_pkg::S_STORE: begin
        if (sts.out_free) begin
          cmd.we       = 1'b1;
          cmd.wsel_in  = 1'b1;
          cmd.waddr    = at_r[prl_pkg::IDX_W-1:0];
          cmd.inc      = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_idx  = prl_pkg::EIDX_W'(at_r);
          cmd.out_last = 1'b1;
          state_nxt    = prl_pkg::S_IDLE;
        end
      end

      prl_pkg::S_DEL_DONE: begin
        if (sts.out_free) begin
          cmd.dec      = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_idx  = prl_pkg::EIDX_W'(at_r);
          cmd.out_last = 1'b1;
          state_nxt    = prl_pkg::S_IDLE;
        end
      end

      prl_pkg::S_RA_RD: begin
        state_nxt = prl_pkg::S_RA_OUT;
      end

      prl_pkg::S_RA_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_rec  = 1'b1;
          cmd.out_last = lst;
          if (lst) begin
            state_nxt = prl_pkg::S_IDLE;
          end else begin
            ptr_nxt   = prl_pkg::CNT_W'(p + 1);
            state_nxt = prl_pkg::S_RA_RD;
          end
        end
      end

      prl_pkg::S_SR_RD: begin
        state_nxt = prl_pkg::S_SR_CMP;
      end

      prl_pkg::S_SR_CMP: begin
        if (sts.key_match) begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            cmd.out_rec  = 1'b1;
            cmd.out_last = 1'b1;
            state_nxt    = prl_pkg::S_IDLE;
          end
        end else if ((p + 1) >= cnt) begin
          if (sts.out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = prl_pkg::ST_NOTFOUND;
            cmd.out_idx    = '0;
            cmd.out_last   = 1'b1;
            state_nxt      = prl_pkg::S_IDLE;
          end
        end else begin
          ptr_nxt   = prl_pkg::CNT_W'(p + 1);
          state_nxt = prl_pkg::S_SR_RD;
        end
      end

      prl_pkg::S_UP_RD: begin
        state_nxt = prl_pkg::S_UP_WR;
      end

      prl_pkg::S_UP_WR: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_rec  = 1'b1;
          cmd.out_last = 1'b1;
          cmd.we       = 1'b1;
          cmd.wsel_in  = 1'b1;
          state_nxt    = prl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = prl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/prl_checker.sv]
// port-level checks for positional_record_list_unit, attached with bind
// depends on prl_pkg
`default_nettype none

module prl_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [prl_pkg::STAT_W-1:0] out_status,
  input wire logic [prl_pkg::EIDX_W-1:0] out_entry_index,
  input wire logic [prl_pkg::ECNT_W-1:0] out_entry_count,
  input wire logic                       out_last,
  input wire logic signed [31:0]         out_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id)
      && $stable(out_last) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second operation taken while one is in flight");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != prl_pkg::ST_OK |-> out_last && out_entry_index == '0)
    else $error("error beat not last or index not zero");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == prl_pkg::ST_EMPTY |-> out_entry_count == '0)
    else $error("empty status with nonzero count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= prl_pkg::CAPACITY)
    else $error("entry count above capacity");

endmodule

bind positional_record_list_unit prl_checker u_prl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_index (out_ch.entry_index),
  .out_entry_count (out_ch.entry_count),
  .out_last        (out_ch.last),
  .out_id          (out_ch.out_id)
);

`default_nettype wire
